FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of this block.
// No dependencies; included by file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CPA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CPA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/cpa_pkg.sv
// Shared constants, codes and payload types of the crossbar port arbiter.
// No dependencies; used by every other file of the block but assert_macros.svh.
package cpa_pkg;

   // sizes
   localparam int PORTS     = 4;
   localparam int PRIO_BITS = 8;
   localparam int PORT_W    = $clog2(PORTS);
   localparam int SLOT_W    = 2;
   localparam int GRID_W    = 3;
   localparam int MODE_W    = 2;
   localparam int COUNT_W   = 3;
   localparam int TOTAL_W   = 32;
   localparam int LIN_W     = SLOT_W + GRID_W;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_COLS = CSR_IDX_W'(2);

   // reset values of the configuration registers
   localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(2);

   typedef enum logic [MODE_W-1:0] {
      MODE_FULL = 2'd0,
      MODE_RR   = 2'd1,
      MODE_PRIO = 2'd2,
      MODE_OFF  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_TAKE,
      ST_WRITE
   } state_type;

   typedef logic [PORTS-1:0][SLOT_W-1:0]    slot_vec_type;
   typedef logic [PORTS-1:0][PRIO_BITS-1:0] prio_vec_type;

   typedef struct packed {
      logic [PORTS-1:0] in_valid;
      slot_vec_type     dest_rows;
      slot_vec_type     dest_cols;
      prio_vec_type     priorities;
      slot_vec_type     out_space;
   } req_type;

   typedef struct packed {
      logic [PORTS-1:0]   taken_mask;
      logic [PORTS-1:0]   delivered_mask;
      slot_vec_type       dest_ports;
      logic [COUNT_W-1:0] delivered_count;
      logic [TOTAL_W-1:0] total_delivered;
   } rsp_type;

   // what the shared unit reports for the input under test
   typedef struct packed {
      logic              in_grid;
      logic [PORT_W-1:0] port;
      logic              has_space;
      logic              prio_wins;
   } unit_res_type;

endpackage

FILE: rtl/cpa_ifs.sv
// Valid/ready channel interfaces for requests and results.
// Depends on cpa_pkg for the payload types.
interface cpa_req_if;
   logic             valid;
   logic             ready;
   cpa_pkg::req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface cpa_rsp_if;
   logic             valid;
   logic             ready;
   cpa_pkg::rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/crossbar_port_arbiter_top.sv
// Crossbar port arbiter: top level with configuration registers and
// result register. Depends on cpa_pkg, cpa_ifs and cpa_seq.
//
// Use:
//   req_bus carries one crossbar cycle per request: input valid mask,
//   destination row/column per input, priorities and output free slots.
//   rsp_bus returns one result per request: taken and delivered masks,
//   resolved output ports, the delivered count and the running total.
//   csr_wr_en/csr_index/csr_wdata write mode (0), grid rows (1) and grid
//   columns (2); write them only while no request is in flight.
// Operation:
//   A request is accepted in the idle cycle, then the inputs are walked
//   one per cycle through the shared compare unit; priority mode adds a
//   take step for the winner, and a write step loads the result register.
//   The result register frees the core: the next request is taken while
//   the previous result still waits; if the receiver stalls past that,
//   the core holds in its write step and req_bus.ready stays low.
// Reset:
//   Synchronous, active high: mode full forwarding, 2x2 grid, round-robin
//   pointer and running total cleared, no result pending.
module crossbar_port_arbiter_top (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [cpa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [cpa_pkg::CSR_DATA_W-1:0]    csr_wdata,
   cpa_req_if.sink                           req_bus,
   cpa_rsp_if.source                         rsp_bus
);

   logic [cpa_pkg::MODE_W-1:0] mode_ff;
   logic [cpa_pkg::GRID_W-1:0] rows_ff;
   logic [cpa_pkg::GRID_W-1:0] cols_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   cpa_pkg::rsp_type           rsp_data_ff;
   cpa_pkg::rsp_type           seq_data;
   logic                       out_free;
   logic                       push;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= cpa_pkg::MODE_FULL;
         rows_ff <= cpa_pkg::GRID_RESET;
         cols_ff <= cpa_pkg::GRID_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            cpa_pkg::CSR_MODE: mode_ff <= csr_wdata[cpa_pkg::MODE_W-1:0];
            cpa_pkg::CSR_ROWS: rows_ff <= csr_wdata[cpa_pkg::GRID_W-1:0];
            cpa_pkg::CSR_COLS: cols_ff <= csr_wdata[cpa_pkg::GRID_W-1:0];
            default: ;
         endcase
      end
   end

   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   cpa_seq u_seq (
      .clock     (clock),
      .reset     (reset),
      .mode      (cpa_pkg::mode_type'(mode_ff)),
      .grid_rows (rows_ff),
      .grid_cols (cols_ff),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .req_data  (req_bus.payload),
      .out_free  (out_free),
      .push      (push),
      .rsp_data  (seq_data)
   );

   // result register
   always_comb begin
      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_data_ff <= seq_data;
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_data_ff;

endmodule

FILE: rtl/cpa_unit.sv
// Shared destination / space / priority compare unit, used once per scan step and in the take step.
// Depends on cpa_pkg.
module cpa_unit (
   input  logic [cpa_pkg::SLOT_W-1:0]    row,
   input  logic [cpa_pkg::SLOT_W-1:0]    col,
   input  logic [cpa_pkg::GRID_W-1:0]    grid_rows,
   input  logic [cpa_pkg::GRID_W-1:0]    grid_cols,
   input  cpa_pkg::slot_vec_type         space,
   input  logic [cpa_pkg::PRIO_BITS-1:0] prio,
   input  logic [cpa_pkg::PRIO_BITS-1:0] best_prio,
   input  logic                          found,
   output cpa_pkg::unit_res_type         res
);

   logic [cpa_pkg::LIN_W-1:0] prod;
   logic [cpa_pkg::LIN_W-1:0] lin;

   // linear port index = row * cols + col
   assign prod = cpa_pkg::LIN_W'(row) * cpa_pkg::LIN_W'(grid_cols);
   assign lin  = prod + cpa_pkg::LIN_W'(col);

   always_comb begin
      res.in_grid   = (cpa_pkg::GRID_W'(row) < grid_rows)
                   && (cpa_pkg::GRID_W'(col) < grid_cols)
                   && (lin < cpa_pkg::LIN_W'(cpa_pkg::PORTS));
      res.port      = lin[cpa_pkg::PORT_W-1:0];
      res.has_space = (space[res.port] != '0);
      res.prio_wins = !found || (prio > best_prio);
   end

endmodule

FILE: rtl/cpa_seq.sv
// Scan sequencer: walks the inputs one per cycle through the shared unit
// and builds one result. Depends on cpa_pkg and cpa_unit.
module cpa_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  cpa_pkg::mode_type           mode,
   input  logic [cpa_pkg::GRID_W-1:0]  grid_rows,
   input  logic [cpa_pkg::GRID_W-1:0]  grid_cols,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  cpa_pkg::req_type            req_data,
   input  logic                        out_free,
   output logic                        push,
   output cpa_pkg::rsp_type            rsp_data
);

   cpa_pkg::state_type state_ff, state_in;
   logic [cpa_pkg::PORT_W-1:0]    step_ff, step_in;
   logic [cpa_pkg::PORT_W-1:0]    last_ff, last_in;
   logic [cpa_pkg::TOTAL_W-1:0]   total_ff, total_in;

   // latched request and per-item work registers
   logic [cpa_pkg::PORTS-1:0]     valid_ff, valid_in;
   cpa_pkg::slot_vec_type         rows_ff, rows_in;
   cpa_pkg::slot_vec_type         cols_ff, cols_in;
   cpa_pkg::prio_vec_type         prios_ff, prios_in;
   cpa_pkg::slot_vec_type         space_ff, space_in;
   logic [cpa_pkg::PORTS-1:0]     taken_ff, taken_in;
   logic [cpa_pkg::PORTS-1:0]     deliv_ff, deliv_in;
   cpa_pkg::slot_vec_type         ports_ff, ports_in;
   logic [cpa_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic                          done_ff, done_in;
   logic                          found_ff, found_in;
   logic [cpa_pkg::PORT_W-1:0]    best_ff, best_in;
   logic [cpa_pkg::PRIO_BITS-1:0] bestp_ff, bestp_in;

   logic [cpa_pkg::PORT_W:0]      rr_sum;
   logic [cpa_pkg::PORT_W-1:0]    rr_idx;
   logic [cpa_pkg::PORT_W-1:0]    scan_idx;
   logic [cpa_pkg::PORT_W-1:0]    unit_idx;
   logic                          do_take;
   cpa_pkg::unit_res_type         res;

   // round-robin index: last served + 1 + step, wrapped
   assign rr_sum = cpa_pkg::PORT_W'(1) + {1'b0, last_ff} + {1'b0, step_ff};
   assign rr_idx = (rr_sum >= (cpa_pkg::PORT_W+1)'(cpa_pkg::PORTS))
                 ? cpa_pkg::PORT_W'(rr_sum - (cpa_pkg::PORT_W+1)'(cpa_pkg::PORTS))
                 : rr_sum[cpa_pkg::PORT_W-1:0];
   assign scan_idx = (mode == cpa_pkg::MODE_RR) ? rr_idx : step_ff;
   assign unit_idx = (state_ff == cpa_pkg::ST_TAKE) ? best_ff : scan_idx;

   cpa_unit u_unit (
      .row       (rows_ff[unit_idx]),
      .col       (cols_ff[unit_idx]),
      .grid_rows (grid_rows),
      .grid_cols (grid_cols),
      .space     (space_ff),
      .prio      (prios_ff[unit_idx]),
      .best_prio (bestp_ff),
      .found     (found_ff),
      .res       (res)
   );

   // state and work registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cpa_pkg::ST_IDLE;
         last_ff  <= '0;
         total_ff <= '0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
         total_ff <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      valid_ff <= valid_in;
      rows_ff  <= rows_in;
      cols_ff  <= cols_in;
      prios_ff <= prios_in;
      space_ff <= space_in;
      taken_ff <= taken_in;
      deliv_ff <= deliv_in;
      ports_ff <= ports_in;
      count_ff <= count_in;
      done_ff  <= done_in;
      found_ff <= found_in;
      best_ff  <= best_in;
      bestp_ff <= bestp_in;
   end

   // next state and datapath control
   always_comb begin
      state_in  = state_ff;
      step_in   = step_ff;
      last_in   = last_ff;
      total_in  = total_ff;
      valid_in  = valid_ff;
      rows_in   = rows_ff;
      cols_in   = cols_ff;
      prios_in  = prios_ff;
      space_in  = space_ff;
      taken_in  = taken_ff;
      deliv_in  = deliv_ff;
      ports_in  = ports_ff;
      count_in  = count_ff;
      done_in   = done_ff;
      found_in  = found_ff;
      best_in   = best_ff;
      bestp_in  = bestp_ff;
      req_ready = 1'b0;
      push      = 1'b0;
      do_take   = 1'b0;

      unique case (state_ff)
         cpa_pkg::ST_IDLE: begin
            // no request is taken while reset is held
            req_ready = !reset;
            if (req_valid && req_ready) begin
               valid_in = req_data.in_valid;
               rows_in  = req_data.dest_rows;
               cols_in  = req_data.dest_cols;
               prios_in = req_data.priorities;
               space_in = req_data.out_space;
               taken_in = '0;
               deliv_in = '0;
               ports_in = '0;
               count_in = '0;
               done_in  = 1'b0;
               found_in = 1'b0;
               best_in  = '0;
               bestp_in = '0;
               step_in  = '0;
               state_in = cpa_pkg::ST_SCAN;
            end
         end
         cpa_pkg::ST_SCAN: begin
            unique case (mode)
               cpa_pkg::MODE_FULL: do_take = valid_ff[scan_idx];
               cpa_pkg::MODE_RR:   do_take = valid_ff[scan_idx] && !done_ff;
               cpa_pkg::MODE_PRIO: begin
                  if (valid_ff[scan_idx] && res.prio_wins) begin
                     found_in = 1'b1;
                     best_in  = scan_idx;
                     bestp_in = prios_ff[scan_idx];
                  end
               end
               default: do_take = 1'b0;
            endcase
            step_in = step_ff + cpa_pkg::PORT_W'(1);
            if (step_ff == cpa_pkg::PORT_W'(cpa_pkg::PORTS - 1)) begin
               state_in = (mode == cpa_pkg::MODE_PRIO) ? cpa_pkg::ST_TAKE
                                                       : cpa_pkg::ST_WRITE;
            end
         end
         cpa_pkg::ST_TAKE: begin
            do_take  = found_ff;
            state_in = cpa_pkg::ST_WRITE;
         end
         cpa_pkg::ST_WRITE: begin
            if (out_free) begin
               push     = 1'b1;
               total_in = total_ff + cpa_pkg::TOTAL_W'(count_ff);
               state_in = cpa_pkg::ST_IDLE;
            end
         end
         default: state_in = cpa_pkg::ST_IDLE;
      endcase

      // take the input under test, deliver when in grid and space remains
      if (do_take) begin
         taken_in[unit_idx] = 1'b1;
         if (res.in_grid) begin
            ports_in[unit_idx] = cpa_pkg::SLOT_W'(res.port);
            if (res.has_space) begin
               space_in[res.port] = space_ff[res.port] - cpa_pkg::SLOT_W'(1);
               deliv_in[unit_idx] = 1'b1;
               count_in           = count_ff + cpa_pkg::COUNT_W'(1);
               if (mode == cpa_pkg::MODE_RR) begin
                  done_in = 1'b1;
                  last_in = unit_idx;
               end
            end
         end
      end
   end

   // result as it leaves the write state
   always_comb begin
      rsp_data.taken_mask      = taken_ff;
      rsp_data.delivered_mask  = deliv_ff;
      rsp_data.dest_ports      = ports_ff;
      rsp_data.delivered_count = count_ff;
      rsp_data.total_delivered = total_ff + cpa_pkg::TOTAL_W'(count_ff);
   end

endmodule

FILE: rtl/cpa_checker.sv
// Port-level checks of the crossbar port arbiter, bound to the top level.
// Depends on cpa_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cpa_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input cpa_pkg::rsp_type rsp_payload
);

   // count must match the delivered mask
   `CPA_ASSERT_IMP(a_count_mask, clock, reset, rsp_valid, rsp_payload.delivered_count == cpa_pkg::COUNT_W'($countones(rsp_payload.delivered_mask)), "delivered count differs from delivered mask")

   // only taken packets can be delivered
   `CPA_ASSERT_IMP(a_deliv_taken, clock, reset, rsp_valid, (rsp_payload.delivered_mask & ~rsp_payload.taken_mask) == '0, "delivered packet was not taken")

   // one request at a time: busy right after acceptance
   `CPA_ASSERT_NXT(a_busy_after_req, clock, reset, req_valid && req_ready, !req_ready, "ready after accepted request")

   // stalled result holds
   `CPA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload), "stalled result changed")

endmodule

bind crossbar_port_arbiter_top cpa_checker u_cpa_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_bus.valid),
   .req_ready   (req_bus.ready),
   .rsp_valid   (rsp_bus.valid),
   .rsp_ready   (rsp_bus.ready),
   .rsp_payload (rsp_bus.payload)
);

FILE: bench/tb_top.sv
// Self-checking bench for crossbar_port_arbiter_top: a directed pass, then
// random requests under many register settings with bursty send and stalls.
// Depends on cpa_pkg, cpa_ifs and the crossbar_port_arbiter_top RTL.
module tb_top;

   localparam int ITEMS_PER_PHASE  = 128;
   localparam int RANDOM_PHASES    = 12;
   localparam int LONG_HOLD_CYCLES = 150;
   localparam int MAX_REPORTS      = 10;

   logic                           clock;
   logic                           reset;
   logic                           csr_wr_en;
   logic [cpa_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [cpa_pkg::CSR_DATA_W-1:0] csr_wdata;

   cpa_req_if req_if ();
   cpa_rsp_if rsp_if ();

   crossbar_port_arbiter_top dut (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_if),
      .rsp_bus   (rsp_if)
   );

   // shadow copy of the arbiter registers and state
   cpa_pkg::mode_type           arb_mode;
   logic [cpa_pkg::GRID_W-1:0]  arb_rows;
   logic [cpa_pkg::GRID_W-1:0]  arb_cols;
   logic [cpa_pkg::PORT_W-1:0]  rr_last;
   logic [cpa_pkg::TOTAL_W-1:0] delivered_sum;

   cpa_pkg::req_type pending_reqs [$];
   cpa_pkg::rsp_type expected_rsps [$];

   int requests_sent;
   int results_checked;
   int mismatches;
   int settings_used;

   // sender burst shaping
   int burst_left;
   int gap_left;

   // receiver stall shaping
   int rx_cycle;
   int rx_style;
   int hold_left;
   logic want_long_hold;
   logic hold_done;

   // clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // one crossbar cycle: which inputs are taken, which get delivered
   function automatic cpa_pkg::rsp_type arbitrate(input cpa_pkg::req_type r);
      cpa_pkg::rsp_type res;
      logic [cpa_pkg::SLOT_W-1:0] room [cpa_pkg::PORTS];
      int k;
      int idx;
      int best;
      int row;
      int col;
      int port;
      logic stop;
      res = '0;
      stop = 1'b0;
      best = -1;
      for (k = 0; k < cpa_pkg::PORTS; k++) room[k] = r.out_space[k];
      // highest priority among waiting inputs, lowest index on ties
      for (k = 0; k < cpa_pkg::PORTS; k++)
         if (r.in_valid[k] && (best < 0 || r.priorities[k] > r.priorities[best]))
            best = k;
      for (k = 0; k < cpa_pkg::PORTS && !stop; k++) begin
         idx = (arb_mode == cpa_pkg::MODE_RR) ? (int'(rr_last) + 1 + k) % cpa_pkg::PORTS
                                              : k;
         if (arb_mode == cpa_pkg::MODE_OFF || !r.in_valid[idx]) continue;
         if (arb_mode == cpa_pkg::MODE_PRIO && idx != best) continue;
         res.taken_mask[idx] = 1'b1;
         row = int'(r.dest_rows[idx]);
         col = int'(r.dest_cols[idx]);
         port = row * int'(arb_cols) + col;
         // out of grid: taken and dropped
         if (row >= int'(arb_rows) || col >= int'(arb_cols) || port >= cpa_pkg::PORTS)
            continue;
         res.dest_ports[idx] = port[cpa_pkg::SLOT_W-1:0];
         // output full: taken and discarded
         if (room[port] == '0) continue;
         room[port] = room[port] - cpa_pkg::SLOT_W'(1);
         res.delivered_mask[idx] = 1'b1;
         res.delivered_count = res.delivered_count + cpa_pkg::COUNT_W'(1);
         if (arb_mode == cpa_pkg::MODE_RR) begin
            rr_last = idx[cpa_pkg::PORT_W-1:0];
            stop = 1'b1;
         end
      end
      delivered_sum = delivered_sum + cpa_pkg::TOTAL_W'(res.delivered_count);
      res.total_delivered = delivered_sum;
      return res;
   endfunction

   function automatic void queue_request(input logic [3:0] valid, input logic [7:0] rows,
                                         input logic [7:0] cols, input logic [31:0] prio,
                                         input logic [7:0] space);
      cpa_pkg::req_type r;
      r.in_valid   = valid;
      r.dest_rows  = rows;
      r.dest_cols  = cols;
      r.priorities = prio;
      r.out_space  = space;
      pending_reqs.push_back(r);
   endfunction

   // random request, destinations mostly inside the current grid
   function automatic cpa_pkg::req_type random_request();
      cpa_pkg::req_type r;
      int k;
      int rmax;
      int cmax;
      r = '0;
      rmax = (arb_rows > 4) ? 4 : int'(arb_rows);
      cmax = (arb_cols > 4) ? 4 : int'(arb_cols);
      r.in_valid = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15))
                                               : 4'($urandom_range(1, 15));
      for (k = 0; k < cpa_pkg::PORTS; k++) begin
         if ($urandom_range(0, 4) != 0 && rmax > 0 && cmax > 0) begin
            r.dest_rows[k] = cpa_pkg::SLOT_W'($urandom_range(0, rmax - 1));
            r.dest_cols[k] = cpa_pkg::SLOT_W'($urandom_range(0, cmax - 1));
         end else begin
            r.dest_rows[k] = cpa_pkg::SLOT_W'($urandom_range(0, 3));
            r.dest_cols[k] = cpa_pkg::SLOT_W'($urandom_range(0, 3));
         end
         // narrow priority values make ties common
         case ($urandom_range(0, 3))
            0:       r.priorities[k] = cpa_pkg::PRIO_BITS'($urandom_range(0, 2));
            1:       r.priorities[k] = '1;
            default: r.priorities[k] = cpa_pkg::PRIO_BITS'($urandom);
         endcase
      end
      r.out_space = 8'($urandom);
      if ($urandom_range(0, 3) == 0) r.out_space = r.out_space & 8'($urandom);
      return r;
   endfunction

   task automatic write_csr(input logic [cpa_pkg::CSR_IDX_W-1:0] idx,
                            input logic [cpa_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // only called with nothing in flight
   task automatic set_config(input cpa_pkg::mode_type m,
                             input logic [cpa_pkg::GRID_W-1:0] rows,
                             input logic [cpa_pkg::GRID_W-1:0] cols);
      write_csr(cpa_pkg::CSR_MODE, cpa_pkg::CSR_DATA_W'(m));
      write_csr(cpa_pkg::CSR_ROWS, rows);
      write_csr(cpa_pkg::CSR_COLS, cols);
      arb_mode = m;
      arb_rows = rows;
      arb_cols = cols;
      settings_used++;
   endtask

   // wait until every request is sent and every result is back
   task automatic drain();
      while (pending_reqs.size() != 0 || req_if.valid || expected_rsps.size() != 0)
         @(negedge clock);
   endtask

   task automatic flag_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatches++;
      if (mismatches <= MAX_REPORTS)
         $display("mismatch on %s: expected %0h, got %0h", what, want, got);
   endtask

   // request driver: bursts with random gaps, valid held until accepted
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
         burst_left = 1;
         gap_left = 0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            expected_rsps.push_back(arbitrate(req_if.payload));
            requests_sent++;
         end
         if (!req_if.valid || req_if.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_if.valid <= 1'b0;
            end else if (pending_reqs.size() != 0) begin
               req_if.payload <= pending_reqs.pop_front();
               req_if.valid <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 16);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_if.valid <= 1'b0;
            end
         end
      end
   end

   // result receiver: stall style redrawn from a running cycle count, plus one long hold
   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         rx_cycle = 0;
         rx_style = 0;
         hold_left = 0;
         hold_done = 1'b0;
      end else begin
         rx_cycle++;
         if (rx_cycle % 64 == 0) rx_style = $urandom_range(0, 3);
         if (want_long_hold && !hold_done) begin
            hold_left = LONG_HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            case (rx_style)
               0:       rsp_if.ready <= 1'b1;
               1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
               2:       rsp_if.ready <= ($urandom_range(0, 3) == 0);
               default: rsp_if.ready <= ((rx_cycle % 8) < 5);
            endcase
         end
      end
   end

   // result monitor: compare against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (expected_rsps.size() == 0) begin
            flag_mismatch("unrequested result", 32'h0, rsp_if.payload.total_delivered);
         end else begin
            if (rsp_if.payload.taken_mask !== expected_rsps[0].taken_mask)
               flag_mismatch("taken_mask", 32'(expected_rsps[0].taken_mask),
                             32'(rsp_if.payload.taken_mask));
            if (rsp_if.payload.delivered_mask !== expected_rsps[0].delivered_mask)
               flag_mismatch("delivered_mask", 32'(expected_rsps[0].delivered_mask),
                             32'(rsp_if.payload.delivered_mask));
            if (rsp_if.payload.dest_ports !== expected_rsps[0].dest_ports)
               flag_mismatch("dest_ports", 32'(expected_rsps[0].dest_ports),
                             32'(rsp_if.payload.dest_ports));
            if (rsp_if.payload.delivered_count !== expected_rsps[0].delivered_count)
               flag_mismatch("delivered_count", 32'(expected_rsps[0].delivered_count),
                             32'(rsp_if.payload.delivered_count));
            if (rsp_if.payload.total_delivered !== expected_rsps[0].total_delivered)
               flag_mismatch("total_delivered", expected_rsps[0].total_delivered,
                             rsp_if.payload.total_delivered);
            void'(expected_rsps.pop_front());
            results_checked++;
         end
      end
   end

   // stimulus and end of run
   initial begin
      int p;
      int n;
      cpa_pkg::mode_type m;
      logic [cpa_pkg::GRID_W-1:0] rows;
      logic [cpa_pkg::GRID_W-1:0] cols;
      reset = 1'b1;
      csr_wr_en = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      req_if.valid = 1'b0;
      req_if.payload = '0;
      rsp_if.ready = 1'b0;
      want_long_hold = 1'b0;
      arb_mode = cpa_pkg::MODE_FULL;
      arb_rows = cpa_pkg::GRID_RESET;
      arb_cols = cpa_pkg::GRID_RESET;
      rr_last = '0;
      delivered_sum = '0;
      requests_sent = 0;
      results_checked = 0;
      mismatches = 0;
      settings_used = 1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset settings: forward all on a 2x2 grid
      queue_request(4'h0, 8'hE4, 8'h1B, 32'h01020304, 8'hFF);
      queue_request(4'hF, 8'h00, 8'h00, 32'h00000000, 8'h03);
      queue_request(4'hF, 8'h50, 8'h44, 32'hFFFFFFFF, 8'hFF);
      queue_request(4'hF, 8'hFF, 8'hFF, 32'h12345678, 8'hFF);
      queue_request(4'hA, 8'h50, 8'h44, 32'h00000000, 8'h00);
      drain();

      // round robin: pointer walks, out-of-grid inputs skipped, idle keeps pointer
      set_config(cpa_pkg::MODE_RR, 3'd2, 3'd2);
      repeat (4) queue_request(4'hF, 8'h00, 8'h00, 32'h00000000, 8'h01);
      queue_request(4'hF, 8'h3C, 8'h00, 32'h00000000, 8'h01);
      queue_request(4'h0, 8'h00, 8'h00, 32'h00000000, 8'hFF);
      queue_request(4'h1, 8'h00, 8'h00, 32'h00000000, 8'h00);
      drain();

      // priority: empty input 0 with top priority, max priority, ties, full output
      set_config(cpa_pkg::MODE_PRIO, 3'd2, 3'd2);
      queue_request(4'hE, 8'h50, 8'h44, 32'h808080FF, 8'hFF);
      queue_request(4'hF, 8'h50, 8'h44, 32'hFF000000, 8'hFF);
      queue_request(4'hF, 8'h00, 8'h00, 32'h00000000, 8'hFF);
      queue_request(4'h4, 8'h50, 8'h44, 32'h00000000, 8'h00);
      drain();

      // unused mode takes nothing
      set_config(cpa_pkg::MODE_OFF, 3'd2, 3'd2);
      queue_request(4'hF, 8'h00, 8'h00, 32'h00000000, 8'hFF);
      drain();

      // zero rows: all out of grid
      set_config(cpa_pkg::MODE_FULL, 3'd0, 3'd2);
      queue_request(4'hF, 8'h00, 8'h00, 32'h00000000, 8'hFF);
      drain();

      // one row of four, 4x4 with ports past the last, four rows of one
      set_config(cpa_pkg::MODE_FULL, 3'd1, 3'd4);
      queue_request(4'hF, 8'h00, 8'hE4, 32'h00000000, 8'hFF);
      drain();
      set_config(cpa_pkg::MODE_FULL, 3'd4, 3'd4);
      queue_request(4'hF, 8'hE4, 8'h00, 32'h00000000, 8'hFF);
      drain();
      set_config(cpa_pkg::MODE_FULL, 3'd4, 3'd1);
      queue_request(4'hF, 8'hE4, 8'h00, 32'h00000000, 8'hFF);
      drain();

      // random phases: grid extremes first, then random settings
      for (p = 0; p < RANDOM_PHASES; p++) begin
         case (p)
            0: begin rows = 3'd1; cols = 3'd1; end
            1: begin rows = 3'd4; cols = 3'd4; end
            2: begin rows = 3'd1; cols = 3'd4; end
            3: begin rows = 3'd4; cols = 3'd1; end
            default: begin
               rows = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                                  : 3'($urandom_range(1, 4));
               cols = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(0, 7))
                                                  : 3'($urandom_range(1, 4));
            end
         endcase
         if (p < 6) m = cpa_pkg::mode_type'(p % 3);
         else m = ($urandom_range(0, 9) == 0) ? cpa_pkg::MODE_OFF
                                              : cpa_pkg::mode_type'($urandom_range(0, 2));
         set_config(m, rows, cols);
         for (n = 0; n < ITEMS_PER_PHASE; n++) pending_reqs.push_back(random_request());
         // back-pressure: receiver stops while the sender keeps offering
         if (p == 2) want_long_hold = 1'b1;
         drain();
      end

      repeat (10) @(posedge clock);
      if (expected_rsps.size() != 0)
         flag_mismatch("results never returned", 32'(expected_rsps.size()), 32'h0);
      $display("%0d requests over %0d register settings (all modes, grid extremes)",
               requests_sent, settings_used);
      $display("%0d results checked, %0d packets delivered, %0d mismatches",
               results_checked, delivered_sum, mismatches);
      if (mismatches == 0) begin
         $display("[crossbar_port_arbiter_top] OK");
      end else begin
         $display("[crossbar_port_arbiter_top] ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5000000;
      $display("[crossbar_port_arbiter_top] ERROR");
      $finish;
   end

endmodule
